// ===== rtl/core/eabv_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// eabv_pkg
// Shared constants, types and a helper function for the Euler-angle to
// basis-vector converter.
// ----------------------------------------------------------------------------
package eabv_pkg;

    localparam int ANGLE_BITS_DEF    = 16;
    localparam int FRACTION_BITS_DEF = 14;

    // Internal sine/cosine datapath: unsigned fixed point with WORK_FRAC
    // fraction bits, wide enough that the final rounding is exact.
    localparam int WORK_FRAC  = 44;
    localparam int WORK_WIDTH = 46;
    localparam int HALF_WIDTH = WORK_WIDTH / 2;

    // Number of Horner steps in each series.
    localparam int TERMS = 7;

    // pi/2 in Q1.61.
    localparam logic [61:0] HALF_PI_Q61 = 62'h3243F6A8885A308D;

    // Cycles from the sine/cosine unit's input to its registered output.
    localparam int SC_LATENCY   = 21;
    // Cycles from a queue pop to the result strobe.
    localparam int BACK_LATENCY = SC_LATENCY + 3;
    // Cycles from an accepted item to the edge that takes its result.
    localparam int TOTAL_LATENCY = BACK_LATENCY + 1;

    // Octant classification of one angle.
    typedef struct packed {
        logic [1:0] quad;
        logic       swap;
    } eabv_octant_t;

    function automatic logic [63:0] factorial(input int n);
        logic [63:0] f;
        f = 64'd1;
        for (int i = 2; i <= n; i++)
        begin
            f = f * 64'(i);
        end
        return f;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/eabv_mac.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// eabv_mac
// Two-stage fixed-point multiply-accumulate: r = c +/- (a * b) >> WORK_FRAC.
// ----------------------------------------------------------------------------
module eabv_mac (
    input  logic                               clk,
    input  logic [eabv_pkg::WORK_WIDTH-1:0]    a,
    input  logic [eabv_pkg::WORK_WIDTH-1:0]    b,
    input  logic [eabv_pkg::WORK_WIDTH-1:0]    c,
    input  logic                               sub,
    output logic [eabv_pkg::WORK_WIDTH-1:0]    r
);
    import eabv_pkg::*;

    localparam int W  = WORK_WIDTH;
    localparam int HW = HALF_WIDTH;
    localparam int PW = W + HW;
    localparam int FW = 2 * W;

    logic [PW-1:0] phi_reg;
    logic [PW-1:0] plo_reg;
    logic [W-1:0]  c_reg;
    logic          sub_reg;
    logic [FW-1:0] full;
    logic [W-1:0]  t;
    logic [W-1:0]  r_next;
    logic [W-1:0]  r_reg;

    // The product is split on b into two partial products.
    always_ff @(posedge clk)
    begin
        phi_reg <= PW'(a) * PW'(b[W-1:HW]);
        plo_reg <= PW'(a) * PW'(b[HW-1:0]);
        c_reg   <= c;
        sub_reg <= sub;
    end

    always_comb
    begin
        full   = (FW'(phi_reg) << HW) + FW'(plo_reg);
        t      = full[WORK_FRAC +: W];
        r_next = sub_reg ? (c_reg - t) : (c_reg + t);
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
    end

    assign r = r_reg;

endmodule
`default_nettype wire

// ===== rtl/core/eabv_sincos.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// eabv_sincos
// Pipelined sine and cosine of one binary angle, given as a reduced offset
// within its octant plus the octant classification.
// ----------------------------------------------------------------------------
module eabv_sincos #(
    parameter int ANGLE_BITS    = eabv_pkg::ANGLE_BITS_DEF,
    parameter int FRACTION_BITS = eabv_pkg::FRACTION_BITS_DEF
) (
    input  logic                             clk,
    input  logic [ANGLE_BITS-3:0]            rp,
    input  eabv_pkg::eabv_octant_t           oct,
    output logic signed [FRACTION_BITS+1:0]  sin_val,
    output logic signed [FRACTION_BITS+1:0]  cos_val
);
    import eabv_pkg::*;

    localparam int RB = ANGLE_BITS - 2;
    localparam int W  = WORK_WIDTH;
    localparam int OW = FRACTION_BITS + 2;
    localparam int XPW = RB + 31;
    localparam int XW  = RB + 62;
    localparam int XSH = ANGLE_BITS + 15;
    localparam int RS  = WORK_FRAC - FRACTION_BITS;
    localparam logic [30:0] HP_HI = HALF_PI_Q61[61:31];
    localparam logic [30:0] HP_LO = HALF_PI_Q61[30:0];
    localparam logic [63:0] SIN_F0 = factorial(2 * TERMS + 1);
    localparam logic [63:0] COS_F0 = factorial(2 * TERMS);
    localparam logic [63:0] SIN_C0 = ((64'd1 << WORK_FRAC) + SIN_F0 / 2) / SIN_F0;
    localparam logic [63:0] COS_C0 = ((64'd1 << WORK_FRAC) + COS_F0 / 2) / COS_F0;

    logic [XPW-1:0] xh_reg;
    logic [XPW-1:0] xl_reg;
    logic [XW-1:0]  x_full;
    logic [XW-1:0]  x_shift;
    logic [W-1:0]   x_reg;
    logic [W-1:0]   y;
    logic [W-1:0]   xd_reg [2*TERMS+2];
    logic [W-1:0]   yd_reg [2*TERMS-2];
    logic [W-1:0]   ps [TERMS+1];
    logic [W-1:0]   pc [TERMS+1];
    logic [W-1:0]   sin_w;
    logic [W-1:0]   cd_reg [2];
    eabv_octant_t   od_reg [SC_LATENCY-1];
    logic [W-1:0]   s_rnd;
    logic [W-1:0]   c_rnd;
    logic signed [OW-1:0] s_q;
    logic signed [OW-1:0] c_q;
    logic signed [OW-1:0] qs;
    logic signed [OW-1:0] qc;
    logic signed [OW-1:0] sin_next;
    logic signed [OW-1:0] cos_next;
    logic signed [OW-1:0] sin_reg;
    logic signed [OW-1:0] cos_reg;

    // Angle in radians: the 62-bit constant is split into two halves.
    always_ff @(posedge clk)
    begin
        xh_reg <= XPW'(rp) * XPW'(HP_HI);
        xl_reg <= XPW'(rp) * XPW'(HP_LO);
        x_reg  <= x_shift[W-1:0];
    end

    always_comb
    begin
        x_full  = (XW'(xh_reg) << 31) + XW'(xl_reg);
        x_shift = x_full >> XSH;
    end

    eabv_mac u_sq (
        .clk (clk),
        .a   (x_reg),
        .b   (x_reg),
        .c   ('0),
        .sub (1'b0),
        .r   (y)
    );

    always_ff @(posedge clk)
    begin
        xd_reg[0] <= x_reg;
        for (int i = 1; i < 2 * TERMS + 2; i++)
        begin
            xd_reg[i] <= xd_reg[i-1];
        end
        yd_reg[0] <= y;
        for (int i = 1; i < 2 * TERMS - 2; i++)
        begin
            yd_reg[i] <= yd_reg[i-1];
        end
    end

    assign ps[0] = SIN_C0[W-1:0];
    assign pc[0] = COS_C0[W-1:0];

    // Horner evaluation in x squared, one step per multiplier pair.
    for (genvar i = 0; i < TERMS; i++)
    begin : g_step
        localparam logic [63:0] SF = factorial(2 * (TERMS - 1 - i) + 1);
        localparam logic [63:0] CF = factorial(2 * (TERMS - 1 - i));
        localparam logic [63:0] SC = ((64'd1 << WORK_FRAC) + SF / 2) / SF;
        localparam logic [63:0] CC = ((64'd1 << WORK_FRAC) + CF / 2) / CF;
        logic [W-1:0] y_step;

        if (i == 0)
        begin : g_first
            assign y_step = y;
        end
        else
        begin : g_later
            assign y_step = yd_reg[2*i-1];
        end

        eabv_mac u_sin (
            .clk (clk),
            .a   (y_step),
            .b   (ps[i]),
            .c   (SC[W-1:0]),
            .sub (1'b1),
            .r   (ps[i+1])
        );

        eabv_mac u_cos (
            .clk (clk),
            .a   (y_step),
            .b   (pc[i]),
            .c   (CC[W-1:0]),
            .sub (1'b1),
            .r   (pc[i+1])
        );
    end

    eabv_mac u_sinx (
        .clk (clk),
        .a   (xd_reg[2*TERMS+1]),
        .b   (ps[TERMS]),
        .c   ('0),
        .sub (1'b0),
        .r   (sin_w)
    );

    always_ff @(posedge clk)
    begin
        cd_reg[0] <= pc[TERMS];
        cd_reg[1] <= cd_reg[0];
        od_reg[0] <= oct;
        for (int i = 1; i < SC_LATENCY - 1; i++)
        begin
            od_reg[i] <= od_reg[i-1];
        end
    end

    // Round to the output grid, undo the octant fold, then the quadrant.
    always_comb
    begin
        s_rnd = (sin_w + (W'(1) << (RS - 1))) >> RS;
        c_rnd = (cd_reg[1] + (W'(1) << (RS - 1))) >> RS;
        s_q   = OW'({1'b0, s_rnd[FRACTION_BITS:0]});
        c_q   = OW'({1'b0, c_rnd[FRACTION_BITS:0]});
        qs    = od_reg[SC_LATENCY-2].swap ? c_q : s_q;
        qc    = od_reg[SC_LATENCY-2].swap ? s_q : c_q;
        case (od_reg[SC_LATENCY-2].quad)
            2'd0:
            begin
                sin_next = qs;
                cos_next = qc;
            end
            2'd1:
            begin
                sin_next = qc;
                cos_next = -qs;
            end
            2'd2:
            begin
                sin_next = -qs;
                cos_next = -qc;
            end
            default:
            begin
                sin_next = -qc;
                cos_next = qs;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        sin_reg <= sin_next;
        cos_reg <= cos_next;
    end

    assign sin_val = sin_reg;
    assign cos_val = cos_reg;

endmodule
`default_nettype wire

// ===== rtl/core/eabv_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// eabv_front
// Accepts angle triples, folds each angle into its first octant and holds
// the classified items in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module eabv_front #(
    parameter int ANGLE_BITS = eabv_pkg::ANGLE_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [ANGLE_BITS-1:0]              pitch_angle,
    input  logic [ANGLE_BITS-1:0]              yaw_angle,
    input  logic [ANGLE_BITS-1:0]              roll_angle,
    input  logic                               pop,
    output logic                               busy,
    output logic                               head_valid,
    output logic [3*(ANGLE_BITS-2)-1:0]        head_rp,
    output eabv_pkg::eabv_octant_t [2:0]       head_oct
);
    import eabv_pkg::*;

    localparam int RB = ANGLE_BITS - 2;
    localparam logic [RB-1:0] HALF_Q = RB'(1) << (RB - 1);

    logic [ANGLE_BITS-1:0]  ang [3];
    logic [3*RB-1:0]        rp_new;
    eabv_octant_t [2:0]     oct_new;
    logic [3*RB-1:0]        rp_mem [2];
    eabv_octant_t [2:0]     oct_mem [2];
    logic                   wr_ptr_reg;
    logic                   rd_ptr_reg;
    logic [1:0]             cnt_reg;
    logic [1:0]             cnt_next;
    logic                   push;
    logic                   take;

    assign ang[0] = pitch_angle;
    assign ang[1] = yaw_angle;
    assign ang[2] = roll_angle;

    // An offset past half a quarter turn is mirrored so the series only
    // ever sees angles up to 45 degrees.
    always_comb
    begin
        logic [RB-1:0] r;
        for (int i = 0; i < 3; i++)
        begin
            r                   = ang[i][RB-1:0];
            oct_new[i].quad     = ang[i][ANGLE_BITS-1 -: 2];
            oct_new[i].swap     = r > HALF_Q;
            rp_new[i*RB +: RB]  = oct_new[i].swap ? (RB'(0) - r) : r;
        end
    end

    assign busy       = cnt_reg == 2'd2;
    assign head_valid = cnt_reg != 2'd0;
    assign push       = start && !busy;
    assign take       = pop && head_valid;
    assign cnt_next   = cnt_reg + 2'(push) - 2'(take);
    assign head_rp    = rp_mem[rd_ptr_reg];
    assign head_oct   = oct_mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg ^ push;
            rd_ptr_reg <= rd_ptr_reg ^ take;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            rp_mem[wr_ptr_reg]  <= rp_new;
            oct_mem[wr_ptr_reg] <= oct_new;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/eabv_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// eabv_back
// Computes the three sine/cosine pairs and combines them into the nine
// rounded and saturated basis-vector components.
// ----------------------------------------------------------------------------
module eabv_back #(
    parameter int ANGLE_BITS    = eabv_pkg::ANGLE_BITS_DEF,
    parameter int FRACTION_BITS = eabv_pkg::FRACTION_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               head_valid,
    input  logic [3*(ANGLE_BITS-2)-1:0]        head_rp,
    input  eabv_pkg::eabv_octant_t [2:0]       head_oct,
    output logic                               pop,
    output logic                               done,
    output logic signed [FRACTION_BITS+1:0]    comp [9]
);
    import eabv_pkg::*;

    localparam int RB = ANGLE_BITS - 2;
    localparam int FB = FRACTION_BITS;
    localparam int OW = FB + 2;
    localparam int PW = 2 * FB + 4;
    localparam int TW = 3 * FB + 8;

    logic signed [OW-1:0] s [3];
    logic signed [OW-1:0] c [3];
    logic                 vld_reg [BACK_LATENCY];

    logic signed [PW-1:0] p_cpcy_reg, p_cpsy_reg, p_srsp_reg, p_crsp_reg, p_crsy_reg;
    logic signed [PW-1:0] p_srsy_reg, p_crcy_reg, p_srcy_reg, p_srcp_reg, p_crcp_reg;
    logic signed [OW-1:0] sp_reg, sy_reg, cy_reg;
    logic signed [TW-1:0] v_next [9];
    logic signed [TW-1:0] v_reg [9];
    logic signed [OW-1:0] out_reg [9];

    assign pop = head_valid;

    for (genvar g = 0; g < 3; g++)
    begin : g_angle
        eabv_sincos #(
            .ANGLE_BITS    (ANGLE_BITS),
            .FRACTION_BITS (FRACTION_BITS)
        ) u_sc (
            .clk     (clk),
            .rp      (head_rp[g*RB +: RB]),
            .oct     (head_oct[g]),
            .sin_val (s[g]),
            .cos_val (c[g])
        );
    end

    // Pairwise products; index 0 is pitch, 1 is yaw, 2 is roll.
    always_ff @(posedge clk)
    begin
        p_cpcy_reg <= PW'(c[0]) * PW'(c[1]);
        p_cpsy_reg <= PW'(c[0]) * PW'(s[1]);
        p_srsp_reg <= PW'(s[2]) * PW'(s[0]);
        p_crsp_reg <= PW'(c[2]) * PW'(s[0]);
        p_crsy_reg <= PW'(c[2]) * PW'(s[1]);
        p_srsy_reg <= PW'(s[2]) * PW'(s[1]);
        p_crcy_reg <= PW'(c[2]) * PW'(c[1]);
        p_srcy_reg <= PW'(s[2]) * PW'(c[1]);
        p_srcp_reg <= PW'(s[2]) * PW'(c[0]);
        p_crcp_reg <= PW'(c[2]) * PW'(c[0]);
        sp_reg     <= s[0];
        sy_reg     <= s[1];
        cy_reg     <= c[1];
    end

    // Exact component sums; the mixed terms carry three times the fraction bits, the others twice.
    always_comb
    begin
        v_next[0] = TW'(p_cpcy_reg);
        v_next[1] = TW'(p_cpsy_reg);
        v_next[2] = -(TW'(sp_reg) <<< FB);
        v_next[3] = (TW'(p_crsy_reg) <<< FB) - TW'(p_srsp_reg) * TW'(cy_reg);
        v_next[4] = -(TW'(p_crcy_reg) <<< FB) - TW'(p_srsp_reg) * TW'(sy_reg);
        v_next[5] = -TW'(p_srcp_reg);
        v_next[6] = (TW'(p_srsy_reg) <<< FB) + TW'(p_crsp_reg) * TW'(cy_reg);
        v_next[7] = TW'(p_crsp_reg) * TW'(sy_reg) - (TW'(p_srcy_reg) <<< FB);
        v_next[8] = TW'(p_crcp_reg);
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
    end

    // Round to nearest with ties upward, then clamp to plus or minus one.
    for (genvar i = 0; i < 9; i++)
    begin : g_finish
        localparam int K = (i == 3 || i == 4 || i == 6 || i == 7) ? 2 * FB : FB;
        localparam logic signed [TW-1:0] LIM = TW'(1) <<< FB;
        logic signed [TW-1:0] w;
        logic signed [TW-1:0] q;
        logic signed [TW-1:0] sat;

        always_comb
        begin
            w = v_reg[i] + (TW'(1) <<< (K - 1));
            q = w >>> K;
            if (q > LIM)
            begin
                sat = LIM;
            end
            else if (q < -LIM)
            begin
                sat = -LIM;
            end
            else
            begin
                sat = q;
            end
        end

        always_ff @(posedge clk)
        begin
            out_reg[i] <= OW'(sat);
        end

        assign comp[i] = out_reg[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BACK_LATENCY; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= head_valid;
            for (int i = 1; i < BACK_LATENCY; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    assign done = vld_reg[BACK_LATENCY-1];

endmodule
`default_nettype wire

// ===== rtl/core/euler_angles_to_basis_vectors.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// euler_angles_to_basis_vectors
// Converts pitch, yaw and roll binary angles into the forward, right and up
// basis vectors in signed fixed point.
// ----------------------------------------------------------------------------
// Usage:
// An item is the three angles, 2^ANGLE_BITS units to a full turn. It is
// accepted at a rising edge where start is high and busy is low. Each item
// gives exactly one result: the nine vector components, each in signed
// fixed point with FRACTION_BITS fraction bits and clamped to plus or minus
// one, shown for a single cycle while done is high.
// The front end classifies each angle by octant into a two-entry queue;
// the back end drains it every cycle into a fully pipelined series
// evaluator, so one item is accepted in every cycle and busy stays low in
// normal use. The pipeline depth is set by the Horner chains of the sine
// and cosine series, with each split multiply registered at its partial
// products and at its sum, plus the product stages.
// The receiver cannot hold results off, so nothing ever backs up inside.
// Reset clears the queue and the valid line; no result is produced for
// items in flight at the time of reset.
// ----------------------------------------------------------------------------
module euler_angles_to_basis_vectors #(
    parameter int ANGLE_BITS    = eabv_pkg::ANGLE_BITS_DEF,
    parameter int FRACTION_BITS = eabv_pkg::FRACTION_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [ANGLE_BITS-1:0]            pitch_angle,
    input  logic [ANGLE_BITS-1:0]            yaw_angle,
    input  logic [ANGLE_BITS-1:0]            roll_angle,
    output logic                             done,
    output logic signed [FRACTION_BITS+1:0]  forward_x,
    output logic signed [FRACTION_BITS+1:0]  forward_y,
    output logic signed [FRACTION_BITS+1:0]  forward_z,
    output logic signed [FRACTION_BITS+1:0]  right_x,
    output logic signed [FRACTION_BITS+1:0]  right_y,
    output logic signed [FRACTION_BITS+1:0]  right_z,
    output logic signed [FRACTION_BITS+1:0]  up_x,
    output logic signed [FRACTION_BITS+1:0]  up_y,
    output logic signed [FRACTION_BITS+1:0]  up_z
);
    import eabv_pkg::*;

    logic                              head_valid;
    logic [3*(ANGLE_BITS-2)-1:0]       head_rp;
    eabv_octant_t [2:0]                head_oct;
    logic                              pop;
    logic signed [FRACTION_BITS+1:0]   comp [9];

    // The front end reduces each angle to an octant offset and queues it.
    eabv_front #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .pitch_angle (pitch_angle),
        .yaw_angle   (yaw_angle),
        .roll_angle  (roll_angle),
        .pop         (pop),
        .busy        (busy),
        .head_valid  (head_valid),
        .head_rp     (head_rp),
        .head_oct    (head_oct)
    );

    // The back end evaluates the series and forms the vectors.
    eabv_back #(
        .ANGLE_BITS    (ANGLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_rp    (head_rp),
        .head_oct   (head_oct),
        .pop        (pop),
        .done       (done),
        .comp       (comp)
    );

    assign forward_x = comp[0];
    assign forward_y = comp[1];
    assign forward_z = comp[2];
    assign right_x   = comp[3];
    assign right_y   = comp[4];
    assign right_z   = comp[5];
    assign up_x      = comp[6];
    assign up_y      = comp[7];
    assign up_z      = comp[8];

endmodule
`default_nettype wire

// ===== rtl/core/eabv_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// eabv_checker
// Port-level checks of the converter's latency and of the identity case.
// ----------------------------------------------------------------------------
module eabv_checker #(
    parameter int ANGLE_BITS    = eabv_pkg::ANGLE_BITS_DEF,
    parameter int FRACTION_BITS = eabv_pkg::FRACTION_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic                             busy,
    input  logic [ANGLE_BITS-1:0]            pitch_angle,
    input  logic [ANGLE_BITS-1:0]            yaw_angle,
    input  logic [ANGLE_BITS-1:0]            roll_angle,
    input  logic                             done,
    input  logic signed [FRACTION_BITS+1:0]  forward_x,
    input  logic signed [FRACTION_BITS+1:0]  forward_y,
    input  logic signed [FRACTION_BITS+1:0]  forward_z,
    input  logic signed [FRACTION_BITS+1:0]  right_x,
    input  logic signed [FRACTION_BITS+1:0]  right_y,
    input  logic signed [FRACTION_BITS+1:0]  right_z,
    input  logic signed [FRACTION_BITS+1:0]  up_x,
    input  logic signed [FRACTION_BITS+1:0]  up_y,
    input  logic signed [FRACTION_BITS+1:0]  up_z
);
    import eabv_pkg::*;

    localparam logic signed [FRACTION_BITS+1:0] ONE = (FRACTION_BITS+2)'(1) <<< FRACTION_BITS;

    // Every accepted item yields a result after the fixed latency.
    a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##TOTAL_LATENCY done)
        else $error("result missing after accepted item");

    // No result appears without an item accepted the latency earlier.
    a_latency_bwd: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, TOTAL_LATENCY))
        else $error("result without a matching item");

    // All-zero angles give the identity frame with right along minus y.
    a_identity: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && pitch_angle == '0 && yaw_angle == '0 && roll_angle == '0)
        |-> ##TOTAL_LATENCY (forward_x == ONE && right_y == -ONE && up_z == ONE
                             && forward_z == '0 && right_z == '0 && up_x == '0))
        else $error("identity frame wrong");

endmodule

bind euler_angles_to_basis_vectors eabv_checker #(
    .ANGLE_BITS    (ANGLE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
) u_eabv_checker (.*);
`default_nettype wire
